/* rtl/mlrr_pkg.sv */
// Package for the multilevel round-robin scheduler.
// Holds the field widths, event and status codes, and the controller/datapath types.
// No dependencies.
package mlrr_pkg;

    // Default sizes for the top-level parameters.
    localparam int TASK_SLOTS_DEF = 64;
    localparam int LEVELS_DEF     = 8;
    localparam int TPL_DEF        = 32;

    // Fixed widths of the port fields.
    localparam int KIND_W   = 2;
    localparam int TREQ_W   = 6;
    localparam int LVLIN_W  = 4;
    localparam int PRIO_W   = 8;
    localparam int TID_W    = 6;
    localparam int STAT_W   = 2;
    localparam int SLICE_W  = 8;
    localparam int SERV_W   = 3;

    // Event kinds carried by an input beat.
    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_SLEEP = 2'd2,
        KIND_TICK  = 2'd3
    } t_kind;

    // Per-slot task state.
    typedef enum logic [1:0] {
        TS_FREE  = 2'd0,
        TS_ALLOC = 2'd1,
        TS_RUN   = 2'd2
    } t_tstat;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_SLOT = 2'd1,
        ST_FULL    = 2'd2,
        ST_NO_TASK = 2'd3
    } t_res_st;

    // Controller states.
    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_IDLE, S_DISPATCH,
        S_ALLOC_RD, S_ALLOC_CK,
        S_T_RD, S_T_CK,
        S_PRE_RD, S_PRE_CK,
        S_RM_RD, S_RM_CK, S_SH_RD, S_SH_WR,
        S_ADD, S_TASK_WB, S_TICK_ADV, S_PICK,
        S_FIN_RD, S_FIN_CK, S_FIN_SL, S_OUT
    } t_state;

    // Datapath commands issued by the controller.
    typedef enum logic [4:0] {
        OP_INIT0, OP_INIT1, OP_IDLE, OP_DISPATCH,
        OP_ALLOC_RD, OP_ALLOC_CK,
        OP_T_RD, OP_T_CK,
        OP_PRE_RD, OP_PRE_CK,
        OP_RM_RD, OP_RM_CK, OP_SH_RD, OP_SH_WR,
        OP_ADD, OP_TASK_WB, OP_TICK_ADV, OP_PICK,
        OP_FIN_RD, OP_FIN_CK, OP_FIN_SL, OP_OUT
    } t_op;

    // Status returned by the datapath to the controller.
    typedef struct packed {
        t_kind kind;
        logic  in_range;
        logic  running;
        logic  lvl_change;
        logic  alloc_done;
        logic  pos_end;
        logic  found;
        logic  swc;
        logic  dirty;
        logic  out_free;
    } t_dp_sts;

endpackage

/* rtl/multilevel_round_robin_scheduler.sv */
// Top level of the multilevel round-robin scheduler.
// Joins mlrr_ctrl and mlrr_dp; uses mlrr_pkg.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+-------------------------------------------
//  input    | i_in_valid  / o_in_ready     | i_kind, i_task_req, i_level, i_priority_req
//  result   | o_out_valid / i_out_ready    | o_task_id, o_status, o_switch_now,
//           |                              | o_slice_ticks, o_serving_level
//
// One event is handled at a time; each beat in gives exactly one result beat.
// Allocate reads and checks the task table one slot at a time until a slot is free
// or the last slot is checked. Run and sleep walk one level's member list in the
// member memory, with a read and then a check or a write per entry searched or moved.
// After reset the member memory is set up in S_INIT0 and S_INIT1 before o_in_ready rises.
// A stalled result holds in the output register while the next beat is taken.
module multilevel_round_robin_scheduler #(
    parameter int TASK_SLOTS      = mlrr_pkg::TASK_SLOTS_DEF,
    parameter int LEVELS          = mlrr_pkg::LEVELS_DEF,
    parameter int TASKS_PER_LEVEL = mlrr_pkg::TPL_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mlrr_pkg::KIND_W-1:0]         i_kind,
    input  logic [mlrr_pkg::TREQ_W-1:0]         i_task_req,
    input  logic signed [mlrr_pkg::LVLIN_W-1:0] i_level,
    input  logic [mlrr_pkg::PRIO_W-1:0]         i_priority_req,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mlrr_pkg::TID_W-1:0]          o_task_id,
    output logic [mlrr_pkg::STAT_W-1:0]         o_status,
    output logic                                o_switch_now,
    output logic [mlrr_pkg::SLICE_W-1:0]        o_slice_ticks,
    output logic [mlrr_pkg::SERV_W-1:0]         o_serving_level
);

    mlrr_pkg::t_op     op;
    mlrr_pkg::t_dp_sts sts;
    logic              in_fire;

    // An input beat is taken when the controller is idle.
    assign in_fire = i_in_valid && o_in_ready;

    mlrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_op       (op)
    );

    mlrr_dp #(
        .TASK_SLOTS (TASK_SLOTS),
        .LEVELS     (LEVELS),
        .TPL        (TASKS_PER_LEVEL)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .o_sts           (sts),
        .i_in_fire       (in_fire),
        .i_kind          (i_kind),
        .i_task_req      (i_task_req),
        .i_level         (i_level),
        .i_priority_req  (i_priority_req),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_task_id       (o_task_id),
        .o_status        (o_status),
        .o_switch_now    (o_switch_now),
        .o_slice_ticks   (o_slice_ticks),
        .o_serving_level (o_serving_level)
    );

endmodule

/* rtl/mlrr_ctrl.sv */
// Controller state machine of the multilevel round-robin scheduler.
// Sequences the datapath through one event; uses mlrr_pkg.
module mlrr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mlrr_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output mlrr_pkg::t_op     o_op
);

    mlrr_pkg::t_state r_state;
    mlrr_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlrr_pkg::S_INIT0;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mlrr_pkg::S_INIT0: n_state = mlrr_pkg::S_INIT1;
            mlrr_pkg::S_INIT1: n_state = mlrr_pkg::S_IDLE;
            mlrr_pkg::S_IDLE: begin
                if (i_in_valid) n_state = mlrr_pkg::S_DISPATCH;
            end
            mlrr_pkg::S_DISPATCH: begin
                if (i_sts.kind == mlrr_pkg::KIND_ALLOC) begin
                    n_state = mlrr_pkg::S_ALLOC_RD;
                end else if (i_sts.kind == mlrr_pkg::KIND_TICK) begin
                    n_state = mlrr_pkg::S_PRE_RD;
                end else if (i_sts.in_range) begin
                    n_state = mlrr_pkg::S_T_RD;
                end else begin
                    n_state = mlrr_pkg::S_FIN_RD;
                end
            end
            mlrr_pkg::S_ALLOC_RD: n_state = mlrr_pkg::S_ALLOC_CK;
            mlrr_pkg::S_ALLOC_CK: begin
                n_state = i_sts.alloc_done ? mlrr_pkg::S_OUT : mlrr_pkg::S_ALLOC_RD;
            end
            mlrr_pkg::S_T_RD: n_state = mlrr_pkg::S_T_CK;
            mlrr_pkg::S_T_CK: begin
                if (i_sts.kind == mlrr_pkg::KIND_RUN) begin
                    if (i_sts.running && i_sts.lvl_change) begin
                        n_state = mlrr_pkg::S_RM_RD;
                    end else if (i_sts.running) begin
                        n_state = mlrr_pkg::S_TASK_WB;
                    end else begin
                        n_state = mlrr_pkg::S_ADD;
                    end
                end else begin
                    n_state = i_sts.running ? mlrr_pkg::S_PRE_RD : mlrr_pkg::S_FIN_RD;
                end
            end
            mlrr_pkg::S_PRE_RD: n_state = mlrr_pkg::S_PRE_CK;
            mlrr_pkg::S_PRE_CK: begin
                n_state = (i_sts.kind == mlrr_pkg::KIND_TICK) ? mlrr_pkg::S_TICK_ADV
                                                               : mlrr_pkg::S_RM_RD;
            end
            mlrr_pkg::S_RM_RD: begin
                if (!i_sts.pos_end) begin
                    n_state = mlrr_pkg::S_RM_CK;
                end else if (i_sts.kind == mlrr_pkg::KIND_RUN) begin
                    n_state = mlrr_pkg::S_ADD;
                end else begin
                    n_state = mlrr_pkg::S_TASK_WB;
                end
            end
            mlrr_pkg::S_RM_CK: begin
                n_state = i_sts.found ? mlrr_pkg::S_SH_RD : mlrr_pkg::S_RM_RD;
            end
            mlrr_pkg::S_SH_RD: begin
                if (!i_sts.pos_end) begin
                    n_state = mlrr_pkg::S_SH_WR;
                end else if (i_sts.kind == mlrr_pkg::KIND_RUN) begin
                    n_state = mlrr_pkg::S_ADD;
                end else begin
                    n_state = mlrr_pkg::S_TASK_WB;
                end
            end
            mlrr_pkg::S_SH_WR: n_state = mlrr_pkg::S_SH_RD;
            mlrr_pkg::S_ADD:   n_state = mlrr_pkg::S_TASK_WB;
            mlrr_pkg::S_TASK_WB: begin
                if (i_sts.kind == mlrr_pkg::KIND_SLEEP && i_sts.swc) begin
                    n_state = mlrr_pkg::S_PICK;
                end else begin
                    n_state = mlrr_pkg::S_FIN_RD;
                end
            end
            mlrr_pkg::S_TICK_ADV: begin
                n_state = i_sts.dirty ? mlrr_pkg::S_PICK : mlrr_pkg::S_FIN_RD;
            end
            mlrr_pkg::S_PICK:   n_state = mlrr_pkg::S_FIN_RD;
            mlrr_pkg::S_FIN_RD: n_state = mlrr_pkg::S_FIN_CK;
            mlrr_pkg::S_FIN_CK: n_state = mlrr_pkg::S_FIN_SL;
            mlrr_pkg::S_FIN_SL: n_state = mlrr_pkg::S_OUT;
            mlrr_pkg::S_OUT: begin
                if (i_sts.out_free) n_state = mlrr_pkg::S_IDLE;
            end
            default: n_state = mlrr_pkg::S_IDLE;
        endcase
    end

    // Command decode.
    always_comb begin
        o_in_ready = 1'b0;
        o_op       = mlrr_pkg::OP_IDLE;
        case (r_state)
            mlrr_pkg::S_INIT0:    o_op = mlrr_pkg::OP_INIT0;
            mlrr_pkg::S_INIT1:    o_op = mlrr_pkg::OP_INIT1;
            mlrr_pkg::S_IDLE: begin
                o_op       = mlrr_pkg::OP_IDLE;
                o_in_ready = 1'b1;
            end
            mlrr_pkg::S_DISPATCH: o_op = mlrr_pkg::OP_DISPATCH;
            mlrr_pkg::S_ALLOC_RD: o_op = mlrr_pkg::OP_ALLOC_RD;
            mlrr_pkg::S_ALLOC_CK: o_op = mlrr_pkg::OP_ALLOC_CK;
            mlrr_pkg::S_T_RD:     o_op = mlrr_pkg::OP_T_RD;
            mlrr_pkg::S_T_CK:     o_op = mlrr_pkg::OP_T_CK;
            mlrr_pkg::S_PRE_RD:   o_op = mlrr_pkg::OP_PRE_RD;
            mlrr_pkg::S_PRE_CK:   o_op = mlrr_pkg::OP_PRE_CK;
            mlrr_pkg::S_RM_RD:    o_op = mlrr_pkg::OP_RM_RD;
            mlrr_pkg::S_RM_CK:    o_op = mlrr_pkg::OP_RM_CK;
            mlrr_pkg::S_SH_RD:    o_op = mlrr_pkg::OP_SH_RD;
            mlrr_pkg::S_SH_WR:    o_op = mlrr_pkg::OP_SH_WR;
            mlrr_pkg::S_ADD:      o_op = mlrr_pkg::OP_ADD;
            mlrr_pkg::S_TASK_WB:  o_op = mlrr_pkg::OP_TASK_WB;
            mlrr_pkg::S_TICK_ADV: o_op = mlrr_pkg::OP_TICK_ADV;
            mlrr_pkg::S_PICK:     o_op = mlrr_pkg::OP_PICK;
            mlrr_pkg::S_FIN_RD:   o_op = mlrr_pkg::OP_FIN_RD;
            mlrr_pkg::S_FIN_CK:   o_op = mlrr_pkg::OP_FIN_CK;
            mlrr_pkg::S_FIN_SL:   o_op = mlrr_pkg::OP_FIN_SL;
            mlrr_pkg::S_OUT:      o_op = mlrr_pkg::OP_OUT;
            default:              o_op = mlrr_pkg::OP_IDLE;
        endcase
    end

    // An accepted beat is always followed by a dispatch.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlrr_pkg::S_IDLE && i_in_valid) |=> (r_state == mlrr_pkg::S_DISPATCH))
        else $error("Accepted beat was not dispatched.");

    // The result stage is left only when the output register can take the beat.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlrr_pkg::S_OUT && !i_sts.out_free) |=> (r_state == mlrr_pkg::S_OUT))
        else $error("Result stage left while output was blocked.");

    // Input ready is raised only while the controller is idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == mlrr_pkg::S_IDLE))
        else $error("Input ready raised outside the idle state.");

endmodule

/* rtl/mlrr_dp.sv */
// Datapath of the multilevel round-robin scheduler: task table, level member
// memory, per-level counts and cursors, and the output register. Uses mlrr_pkg.
module mlrr_dp #(
    parameter int TASK_SLOTS = mlrr_pkg::TASK_SLOTS_DEF,
    parameter int LEVELS     = mlrr_pkg::LEVELS_DEF,
    parameter int TPL        = mlrr_pkg::TPL_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mlrr_pkg::t_op                      i_op,
    output mlrr_pkg::t_dp_sts                  o_sts,
    input  logic                               i_in_fire,
    input  logic [mlrr_pkg::KIND_W-1:0]        i_kind,
    input  logic [mlrr_pkg::TREQ_W-1:0]        i_task_req,
    input  logic signed [mlrr_pkg::LVLIN_W-1:0] i_level,
    input  logic [mlrr_pkg::PRIO_W-1:0]        i_priority_req,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [mlrr_pkg::TID_W-1:0]         o_task_id,
    output logic [mlrr_pkg::STAT_W-1:0]        o_status,
    output logic                               o_switch_now,
    output logic [mlrr_pkg::SLICE_W-1:0]       o_slice_ticks,
    output logic [mlrr_pkg::SERV_W-1:0]        o_serving_level
);

    localparam int TW  = $clog2(TASK_SLOTS);
    localparam int LW  = $clog2(LEVELS);
    localparam int PW  = $clog2(TPL);
    localparam int CW  = $clog2(TPL + 1);
    localparam int MD  = LEVELS * TPL;
    localparam int MW  = $clog2(MD);
    localparam int SW  = mlrr_pkg::SLICE_W;
    localparam int TEW = 2 + LW + SW;

    // Latched input beat.
    mlrr_pkg::t_kind             r_kind;
    logic [mlrr_pkg::TREQ_W-1:0] r_treq;
    logic [mlrr_pkg::LVLIN_W-1:0] r_lv;
    logic [mlrr_pkg::PRIO_W-1:0] r_pr;

    // Task table: status, level and slice per slot.
    logic [TEW-1:0]        r_tmem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] r_tvld;
    logic [TEW-1:0]        r_trd;
    logic                  r_trd_vld;
    logic [TW-1:0]         r_trd_addr;

    // Level member lists.
    logic [TW-1:0] r_mmem [MD];
    logic [TW-1:0] r_mrd;

    // Per-level control state.
    logic [CW-1:0] r_cnt [LEVELS];
    logic [PW-1:0] r_cur [LEVELS];
    logic [LW-1:0] r_serv;
    logic          r_dirty;

    // Working registers for one event.
    logic [TW-1:0] r_ai;
    logic [CW-1:0] r_pi;
    logic [1:0]    r_tstat;
    logic [LW-1:0] r_tlvl;
    logic [SW-1:0] r_tslice;
    logic [LW-1:0] r_tgt;
    logic [LW-1:0] r_lvl;
    logic          r_phas;
    logic [TW-1:0] r_pcur;
    logic          r_has;
    logic [TW-1:0] r_ncur;
    logic          r_swc;
    logic [1:0]    r_st;

    // Staged result and output register.
    logic [mlrr_pkg::TID_W-1:0]   r_res_id;
    logic [1:0]                   r_res_st;
    logic                         r_res_sw;
    logic [SW-1:0]                r_res_sl;
    logic [mlrr_pkg::SERV_W-1:0]  r_res_serv;
    logic                         r_out_valid;
    logic [mlrr_pkg::TID_W-1:0]   r_out_id;
    logic [1:0]                   r_out_st;
    logic                         r_out_sw;
    logic [SW-1:0]                r_out_sl;
    logic [mlrr_pkg::SERV_W-1:0]  r_out_serv;

    logic [TW-1:0]  t_idx;
    logic           in_range;
    logic [TEW-1:0] trst;
    logic [TEW-1:0] tinfo;
    logic [1:0]     ti_stat;
    logic [LW-1:0]  ti_lvl;
    logic [SW-1:0]  ti_slice;
    logic [LW-1:0]  tgt;
    logic [LW-1:0]  lsel;
    logic [CW-1:0]  cnt_s;
    logic [PW-1:0]  cur_s;
    logic [PW-1:0]  cur_pos;
    logic [MW-1:0]  mra;
    logic           mwe;
    logic [MW-1:0]  mwa;
    logic [TW-1:0]  mwd;
    logic [TW-1:0]  tra;
    logic           twe;
    logic [TW-1:0]  twa;
    logic [TEW-1:0] twd;
    logic           alloc_free;
    logic           alloc_last;
    logic           found;
    logic           pos_end;
    logic           full;
    logic           swc;
    logic           out_free;
    logic [LW-1:0]  first_lvl;
    logic [CW-1:0]  rm_n;
    logic [PW-1:0]  rm_cur;
    logic [CW-1:0]  tk_c1;
    logic [PW-1:0]  tk_cur;
    logic           cnt_over;
    logic           cur_bad;
    logic           any_nz;

    function automatic logic [MW-1:0] f_maddr(input logic [LW-1:0] l, input logic [CW-1:0] p);
        return MW'(32'(l) * TPL + 32'(p));
    endfunction

    // Decode of the latched request.
    assign t_idx    = TW'(r_treq);
    assign in_range = (32'(r_treq) < TASK_SLOTS);

    // Task table read, with reset contents for slots never written.
    always_comb begin
        trst = '0;
        if (32'(r_trd_addr) == 0) begin
            trst = {mlrr_pkg::TS_RUN, LW'(0), SW'(2)};
        end else if (32'(r_trd_addr) == 1) begin
            trst = {mlrr_pkg::TS_RUN, LW'(LEVELS - 1), SW'(1)};
        end
    end
    assign tinfo    = r_trd_vld ? r_trd : trst;
    assign ti_stat  = tinfo[TEW-1 -: 2];
    assign ti_lvl   = tinfo[SW +: LW];
    assign ti_slice = tinfo[SW-1:0];

    // Target level of a run request.
    always_comb begin
        if (r_lv[3]) begin
            tgt = ti_lvl;
        end else if (32'(r_lv[2:0]) >= LEVELS) begin
            tgt = LW'(LEVELS - 1);
        end else begin
            tgt = LW'(r_lv[2:0]);
        end
    end

    // Single level select for count and cursor reads.
    always_comb begin
        case (i_op)
            mlrr_pkg::OP_RM_RD, mlrr_pkg::OP_RM_CK,
            mlrr_pkg::OP_SH_RD, mlrr_pkg::OP_SH_WR: lsel = r_lvl;
            mlrr_pkg::OP_ADD:                      lsel = r_tgt;
            default:                               lsel = r_serv;
        endcase
    end
    assign cnt_s   = r_cnt[lsel];
    assign cur_s   = r_cur[lsel];
    assign cur_pos = (CW'(cur_s) >= cnt_s) ? '0 : cur_s;

    // Checks used by the controller.
    assign alloc_free = (ti_stat == mlrr_pkg::TS_FREE);
    assign alloc_last = (32'(r_ai) == TASK_SLOTS - 1);
    assign found      = (r_mrd == t_idx);
    assign pos_end    = (r_pi >= cnt_s);
    assign full       = (cnt_s >= CW'(TPL));
    assign swc        = r_phas && (r_pcur == t_idx);
    assign out_free   = !r_out_valid || i_out_ready;

    // First level with members.
    always_comb begin
        first_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_cnt[i] != '0) first_lvl = LW'(i);
        end
    end

    // Cursor after a removal at position r_pi.
    always_comb begin
        rm_n   = cnt_s - CW'(1);
        rm_cur = cur_s;
        if (r_pi < CW'(cur_s)) rm_cur = cur_s - PW'(1);
        if (CW'(rm_cur) >= rm_n) rm_cur = '0;
    end

    // Cursor after a timer tick.
    always_comb begin
        tk_c1  = CW'(cur_s) + CW'(1);
        tk_cur = '0;
        if (cnt_s != '0 && tk_c1 < cnt_s) tk_cur = PW'(tk_c1);
    end

    // Member memory addressing.
    always_comb begin
        case (i_op)
            mlrr_pkg::OP_PRE_RD, mlrr_pkg::OP_FIN_RD: mra = f_maddr(r_serv, CW'(cur_pos));
            mlrr_pkg::OP_SH_RD: mra = f_maddr(r_lvl, r_pi + CW'(1));
            default:            mra = f_maddr(r_lvl, r_pi);
        endcase
        mwe = 1'b0;
        mwa = f_maddr(r_lvl, r_pi);
        mwd = r_mrd;
        case (i_op)
            mlrr_pkg::OP_INIT0: begin
                mwe = 1'b1;
                mwa = f_maddr(LW'(0), CW'(0));
                mwd = TW'(0);
            end
            mlrr_pkg::OP_INIT1: begin
                mwe = 1'b1;
                mwa = f_maddr(LW'(LEVELS - 1), CW'(0));
                mwd = TW'(1);
            end
            mlrr_pkg::OP_SH_WR: mwe = 1'b1;
            mlrr_pkg::OP_ADD: begin
                mwe = !full;
                mwa = f_maddr(r_tgt, cnt_s);
                mwd = t_idx;
            end
            default: mwe = 1'b0;
        endcase
    end

    // Task table addressing.
    always_comb begin
        case (i_op)
            mlrr_pkg::OP_T_RD:  tra = t_idx;
            mlrr_pkg::OP_FIN_CK: tra = r_mrd;
            default:            tra = r_ai;
        endcase
        twe = 1'b0;
        twa = t_idx;
        twd = {r_tstat, r_tlvl, r_tslice};
        case (i_op)
            mlrr_pkg::OP_ALLOC_CK: begin
                twe = alloc_free;
                twa = r_ai;
                twd = {mlrr_pkg::TS_ALLOC, ti_lvl, ti_slice};
            end
            mlrr_pkg::OP_TASK_WB: twe = 1'b1;
            default:             twe = 1'b0;
        endcase
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (twe) r_tmem[twa] <= twd;
        r_trd      <= r_tmem[tra];
        r_trd_addr <= tra;
        if (mwe) r_mmem[mwa] <= mwd;
        r_mrd <= r_mmem[mra];
    end

    // Control state: valid bits, level counts, cursors, serving level, output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld      <= '0;
            r_trd_vld   <= 1'b0;
            r_serv      <= '0;
            r_dirty     <= 1'b1;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                r_cnt[i] <= (i == 0 || i == LEVELS - 1) ? CW'(1) : CW'(0);
                r_cur[i] <= '0;
            end
        end else begin
            r_trd_vld <= r_tvld[tra];
            if (twe) r_tvld[twa] <= 1'b1;
            case (i_op)
                mlrr_pkg::OP_RM_CK: begin
                    if (found) begin
                        r_cnt[lsel] <= rm_n;
                        r_cur[lsel] <= rm_cur;
                    end
                end
                mlrr_pkg::OP_ADD: begin
                    if (!full) r_cnt[lsel] <= cnt_s + CW'(1);
                end
                mlrr_pkg::OP_TASK_WB: begin
                    if (r_kind == mlrr_pkg::KIND_RUN) r_dirty <= 1'b1;
                end
                mlrr_pkg::OP_TICK_ADV: r_cur[lsel] <= tk_cur;
                mlrr_pkg::OP_PICK: begin
                    r_serv  <= first_lvl;
                    r_dirty <= 1'b0;
                end
                default: ;
            endcase
            if (i_op == mlrr_pkg::OP_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the event in flight.
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_kind <= mlrr_pkg::t_kind'(i_kind);
            r_treq <= i_task_req;
            r_lv   <= i_level;
            r_pr   <= i_priority_req;
        end
        case (i_op)
            mlrr_pkg::OP_DISPATCH: begin
                r_ai  <= '0;
                r_st  <= mlrr_pkg::ST_OK;
                r_swc <= 1'b0;
                r_phas <= 1'b0;
            end
            mlrr_pkg::OP_ALLOC_CK: begin
                r_ai <= r_ai + TW'(1);
                if (alloc_free || alloc_last) begin
                    r_res_id   <= alloc_free ? mlrr_pkg::TID_W'(r_ai) : '0;
                    r_res_st   <= alloc_free ? mlrr_pkg::ST_OK : mlrr_pkg::ST_NO_SLOT;
                    r_res_sw   <= 1'b0;
                    r_res_sl   <= '0;
                    r_res_serv <= mlrr_pkg::SERV_W'(r_serv);
                end
            end
            mlrr_pkg::OP_T_CK: begin
                r_tstat  <= ti_stat;
                r_tlvl   <= ti_lvl;
                r_tslice <= (r_kind == mlrr_pkg::KIND_RUN && r_pr != '0) ? r_pr : ti_slice;
                r_tgt    <= tgt;
                r_lvl    <= ti_lvl;
                r_pi     <= '0;
            end
            mlrr_pkg::OP_PRE_RD: r_phas <= (cnt_s != '0);
            mlrr_pkg::OP_PRE_CK: begin
                r_pcur <= r_mrd;
                r_pi   <= '0;
            end
            mlrr_pkg::OP_RM_RD: r_tstat <= mlrr_pkg::TS_ALLOC;
            mlrr_pkg::OP_RM_CK: begin
                if (!found) r_pi <= r_pi + CW'(1);
            end
            mlrr_pkg::OP_SH_WR: r_pi <= r_pi + CW'(1);
            mlrr_pkg::OP_ADD: begin
                r_tlvl <= r_tgt;
                if (full) begin
                    r_st <= mlrr_pkg::ST_FULL;
                end else begin
                    r_tstat <= mlrr_pkg::TS_RUN;
                end
            end
            mlrr_pkg::OP_TASK_WB: r_swc <= swc;
            mlrr_pkg::OP_FIN_RD:  r_has <= (cnt_s != '0);
            mlrr_pkg::OP_FIN_CK:  r_ncur <= r_mrd;
            mlrr_pkg::OP_FIN_SL: begin
                r_res_serv <= mlrr_pkg::SERV_W'(r_serv);
                if (r_has) begin
                    r_res_id <= mlrr_pkg::TID_W'(r_ncur);
                    r_res_sl <= ti_slice;
                    r_res_st <= r_st;
                    if (r_kind == mlrr_pkg::KIND_TICK) begin
                        r_res_sw <= !r_phas || (r_ncur != r_pcur);
                    end else if (r_kind == mlrr_pkg::KIND_SLEEP) begin
                        r_res_sw <= r_swc;
                    end else begin
                        r_res_sw <= 1'b0;
                    end
                end else begin
                    r_res_id <= '0;
                    r_res_sl <= '0;
                    r_res_sw <= 1'b0;
                    r_res_st <= (r_st == mlrr_pkg::ST_OK) ? mlrr_pkg::ST_NO_TASK : r_st;
                end
            end
            mlrr_pkg::OP_OUT: begin
                if (out_free) begin
                    r_out_id   <= r_res_id;
                    r_out_st   <= r_res_st;
                    r_out_sw   <= r_res_sw;
                    r_out_sl   <= r_res_sl;
                    r_out_serv <= r_res_serv;
                end
            end
            default: ;
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_sts.kind       = r_kind;
        o_sts.in_range   = in_range;
        o_sts.running    = (ti_stat == mlrr_pkg::TS_RUN);
        o_sts.lvl_change = (ti_lvl != tgt);
        o_sts.alloc_done = alloc_free || alloc_last;
        o_sts.pos_end    = pos_end;
        o_sts.found      = found;
        o_sts.swc        = swc;
        o_sts.dirty      = r_dirty;
        o_sts.out_free   = out_free;
    end

    assign o_out_valid     = r_out_valid;
    assign o_task_id       = r_out_id;
    assign o_status        = r_out_st;
    assign o_switch_now    = r_out_sw;
    assign o_slice_ticks   = r_out_sl;
    assign o_serving_level = r_out_serv;

    // Invariants over all levels.
    always_comb begin
        cnt_over = 1'b0;
        cur_bad  = 1'b0;
        any_nz   = 1'b0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_cnt[i] > CW'(TPL)) cnt_over = 1'b1;
            if (r_cur[i] != '0 && CW'(r_cur[i]) >= r_cnt[i]) cur_bad = 1'b1;
            if (r_cnt[i] != '0) any_nz = 1'b1;
        end
    end

    // No level ever holds more members than a list can store.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !cnt_over)
        else $error("Level member count exceeds list capacity.");

    // A cursor always points inside its list, or rests at zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !cur_bad)
        else $error("Level cursor outside its member list.");

    // After a level pick, the serving level has members unless all levels are empty.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == mlrr_pkg::OP_PICK) |=> (r_cnt[r_serv] != '0 || !any_nz))
        else $error("Picked serving level has no members.");

endmodule
